/* design/eds_pkg.sv */
// shared constants, types and tables for the epoch to dos date/time converter
package eds_pkg;

  // clamp limits: 1980-01-01 00:00:00 and 2100-01-01 00:00:00
  localparam logic [31:0] FirstSecond = 32'd315532800;
  localparam logic [31:0] EndSecond   = 32'd4102444800;
  localparam logic [31:0] LastSecond  = EndSecond - 32'd1;

  localparam logic [15:0] DaysTo1980  = 16'd3652;

  // seconds per day is 675 << 7, the shifted part is split off first
  localparam int          DayShift    = 25;
  localparam logic [9:0]  DayLow      = 10'd675;
  localparam logic [15:0] DayRecip    = 16'((64'd1 << DayShift) / 64'd675);

  localparam int          QuadShift   = 16;
  localparam logic [10:0] QuadDays    = 11'd1461;
  localparam logic [5:0]  QuadRecip   = 6'((64'd1 << QuadShift) / 64'd1461);

  localparam int          HourShift   = 17;
  localparam logic [11:0] HourSecs    = 12'd3600;
  localparam logic [5:0]  HourRecip   = 6'((64'd1 << HourShift) / 64'd3600);

  localparam int          MinShift    = 20;
  localparam logic [5:0]  MinSecs     = 6'd60;
  localparam logic [14:0] MinRecip    = 15'(((64'd1 << MinShift) / 64'd60) + 64'd1);

  // day-of-year boundaries inside a four-year block
  localparam logic [10:0] Year1Start  = 11'd366;
  localparam logic [10:0] Year2Start  = 11'd731;
  localparam logic [10:0] Year3Start  = 11'd1096;

  // clamped date/time results: before 1980 (MinDate) and after the end of 2099
  localparam logic [15:0] MaxTime     = 16'hBF7D;
  localparam logic [15:0] MaxDate     = 16'hEF9F;
  localparam logic [15:0] MinDate     = 16'h0021;

  localparam int          Latency     = 8;

  // day number split into whole days since 1980 and second of the day
  typedef struct packed {
    logic        valid;
    logic        clamped;
    logic [15:0] day_num;
    logic [16:0] day_sec;
  } eds_split_t;

  // days before the first of month m in a common year, m = 0 .. 12
  function automatic logic [8:0] month_start(input logic [3:0] m);
    logic [8:0] v;
    v = 9'd0;
    unique case (m)
      4'd0:    v = 9'd0;
      4'd1:    v = 9'd31;
      4'd2:    v = 9'd59;
      4'd3:    v = 9'd90;
      4'd4:    v = 9'd120;
      4'd5:    v = 9'd151;
      4'd6:    v = 9'd181;
      4'd7:    v = 9'd212;
      4'd8:    v = 9'd243;
      4'd9:    v = 9'd273;
      4'd10:   v = 9'd304;
      4'd11:   v = 9'd334;
      4'd12:   v = 9'd365;
      default: v = 9'd0;
    endcase
    return v;
  endfunction

endpackage

/* design/eds_split.sv */
// front stages: range clamp and split of the seconds count into day and second of day
module eds_split
  import eds_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] epoch_seconds_i,
  output eds_split_t  split_o
);

  // stage 1: clamp
  logic        valid1_q, flag1_q, flag1_d;
  logic [31:0] s1_q, s1_d;

  always_comb begin
    s1_d    = epoch_seconds_i;
    flag1_d = 1'b0;
    if (epoch_seconds_i < FirstSecond) begin
      s1_d    = FirstSecond;
      flag1_d = 1'b1;
    end else if (epoch_seconds_i >= EndSecond) begin
      s1_d    = LastSecond;
      flag1_d = 1'b1;
    end
  end

  // stage 2: quotient estimate, low by at most one
  logic        valid2_q, flag2_q;
  logic [24:0] x2_q;
  logic [6:0]  low2_q;
  logic [15:0] q2_q, q2_d;
  logic [40:0] day_prod;

  assign day_prod = 41'(s1_q[31:7]) * 41'(DayRecip);
  assign q2_d     = day_prod[40:25];

  // stage 3: correction
  logic        valid3_q, flag3_q;
  logic [15:0] days3_q, days3_d;
  logic [16:0] sec3_q, sec3_d;
  logic [25:0] q_mul, r_wide;
  logic [10:0] r_est;
  logic [15:0] q_fix;
  logic [9:0]  r_fix;

  always_comb begin
    q_mul  = 26'(q2_q) * 26'(DayLow);
    r_wide = 26'(x2_q) - q_mul;
    r_est  = r_wide[10:0];
    q_fix  = q2_q;
    r_fix  = r_est[9:0];
    if (r_est >= 11'(DayLow)) begin
      q_fix = q2_q + 16'd1;
      r_fix = 10'(r_est - 11'(DayLow));
    end
    days3_d = q_fix - DaysTo1980;
    sec3_d  = {r_fix, low2_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid1_q <= 1'b0;
      valid2_q <= 1'b0;
      valid3_q <= 1'b0;
    end else begin
      valid1_q <= start_i;
      valid2_q <= valid1_q;
      valid3_q <= valid2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_q    <= s1_d;
    flag1_q <= flag1_d;
    x2_q    <= s1_q[31:7];
    low2_q  <= s1_q[6:0];
    q2_q    <= q2_d;
    flag2_q <= flag1_q;
    days3_q <= days3_d;
    sec3_q  <= sec3_d;
    flag3_q <= flag2_q;
  end

  assign split_o = '{valid: valid3_q, clamped: flag3_q, day_num: days3_q, day_sec: sec3_q};

endmodule

/* design/eds_tod.sv */
// time-of-day stages: hour, minute and halved second packed into the dos time word
module eds_tod
  import eds_pkg::*;
(
  input  logic        clk_i,
  input  logic [16:0] day_sec_i,
  output logic [15:0] dos_time_o
);

  // hour estimate
  logic [16:0] s4_q;
  logic [4:0]  h4_q;
  logic [22:0] h_prod;

  assign h_prod = 23'(day_sec_i) * 23'(HourRecip);

  // hour correction, second of the hour
  logic [4:0]  h5_q, h5_d;
  logic [11:0] m5_q, m5_d;
  logic [16:0] h_mul, m_wide;
  logic [12:0] m_est;

  always_comb begin
    h_mul  = 17'(h4_q) * 17'(HourSecs);
    m_wide = s4_q - h_mul;
    m_est  = m_wide[12:0];
    h5_d   = h4_q;
    m5_d   = m_est[11:0];
    if (m_est >= 13'(HourSecs)) begin
      h5_d = h4_q + 5'd1;
      m5_d = 12'(m_est - 13'(HourSecs));
    end
  end

  // minute, exact for every second of an hour
  logic [4:0]  h6_q;
  logic [11:0] m6_q;
  logic [5:0]  min6_q;
  logic [26:0] mn_prod;

  assign mn_prod = 27'(m5_q) * 27'(MinRecip);

  // second and pack
  logic [11:0] mn_mul, sec_wide;
  logic [15:0] time7_q;

  assign mn_mul   = 12'(min6_q) * 12'(MinSecs);
  assign sec_wide = m6_q - mn_mul;

  always_ff @(posedge clk_i) begin
    s4_q    <= day_sec_i;
    h4_q    <= h_prod[21:17];
    h5_q    <= h5_d;
    m5_q    <= m5_d;
    h6_q    <= h5_q;
    m6_q    <= m5_q;
    min6_q  <= mn_prod[25:20];
    time7_q <= {h6_q, min6_q, sec_wide[5:1]};
  end

  assign dos_time_o = time7_q;

endmodule

/* design/eds_cal.sv */
// calendar stages: four-year block, year, month and day packed into the dos date word
module eds_cal
  import eds_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  eds_split_t  split_i,
  output logic        valid_o,
  output logic        clamped_o,
  output logic [15:0] dos_date_o
);

  logic [Latency-4:0] valid_q;
  logic [Latency-4:0] flag_q;

  // block-of-four-years estimate
  logic [15:0] d4_q;
  logic [4:0]  qe4_q;
  logic [21:0] q_prod;

  assign q_prod = 22'(split_i.day_num) * 22'(QuadRecip);

  // correction, day within the block
  logic [4:0]  quad5_q, quad5_d;
  logic [10:0] r5_q, r5_d;
  logic [16:0] q_mul, r_wide;
  logic [11:0] r_est;

  always_comb begin
    q_mul   = 17'(qe4_q) * 17'(QuadDays);
    r_wide  = 17'(d4_q) - q_mul;
    r_est   = r_wide[11:0];
    quad5_d = qe4_q;
    r5_d    = r_est[10:0];
    if (r_est >= 12'(QuadDays)) begin
      quad5_d = qe4_q + 5'd1;
      r5_d    = 11'(r_est - 12'(QuadDays));
    end
  end

  // year within the block, day of year
  logic [6:0]  year6_q, year6_d;
  logic [8:0]  doy6_q, doy6_d;
  logic [1:0]  yoff;
  logic [10:0] doy_wide;

  always_comb begin
    if (r5_q < Year1Start) begin
      yoff     = 2'd0;
      doy_wide = r5_q;
    end else if (r5_q < Year2Start) begin
      yoff     = 2'd1;
      doy_wide = r5_q - Year1Start;
    end else if (r5_q < Year3Start) begin
      yoff     = 2'd2;
      doy_wide = r5_q - Year2Start;
    end else begin
      yoff     = 2'd3;
      doy_wide = r5_q - Year3Start;
    end
    year6_d = {quad5_q, yoff};
    doy6_d  = doy_wide[8:0];
  end

  // month: count of month starts at or below the day of year
  logic [6:0]  year7_q;
  logic [8:0]  doy7_q;
  logic [3:0]  month7_q, month7_d;
  logic        leap6;
  logic [9:0]  mstart;

  assign leap6 = (year6_q[1:0] == 2'd0);

  always_comb begin
    month7_d = 4'd1;
    mstart   = '0;
    for (int m = 1; m < 12; m++) begin
      mstart = 10'(month_start(4'(m))) + 10'(leap6 && (m >= 2));
      if (10'(doy6_q) >= mstart) begin
        month7_d = month7_d + 4'd1;
      end
    end
  end

  // day of month and pack
  logic        leap7;
  logic [9:0]  dstart, day_wide;
  logic [15:0] date8_q;

  assign leap7    = (year7_q[1:0] == 2'd0);
  assign dstart   = 10'(month_start(month7_q - 4'd1)) + 10'(leap7 && (month7_q >= 4'd3));
  assign day_wide = 10'(doy7_q) - dstart + 10'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[Latency-5:0], split_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    flag_q   <= {flag_q[Latency-5:0], split_i.clamped};
    d4_q     <= split_i.day_num;
    qe4_q    <= q_prod[20:16];
    quad5_q  <= quad5_d;
    r5_q     <= r5_d;
    year6_q  <= year6_d;
    doy6_q   <= doy6_d;
    year7_q  <= year6_q;
    doy7_q   <= doy6_q;
    month7_q <= month7_d;
    date8_q  <= {year7_q, month7_q, day_wide[4:0]};
  end

  assign valid_o    = valid_q[Latency-4];
  assign clamped_o  = flag_q[Latency-4];
  assign dos_date_o = date8_q;

endmodule

/* design/epoch_seconds_to_dos_datetime.sv */
// Converts seconds since 1970-01-01 00:00:00 into the packed dos time and date words.
// One timestamp is taken in every clock cycle: busy_o stays low, and the result of a
// start_i beat comes out as a done_o strobe, in input order, after the register stages
// of the constant dividers (clamp, day split estimate and correction, then four-year
// block, year, month and day, with the hour, minute and second split alongside). The
// result is shown for a single cycle only, since the receiver cannot hold it off.
// Inputs before 1980 or from 2100 on are clamped to the nearest end and flagged on
// out_of_range_o.
module epoch_seconds_to_dos_datetime
  import eds_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [31:0] epoch_seconds_i,
  output logic        done_o,
  output logic [15:0] dos_time_o,
  output logic [15:0] dos_date_o,
  output logic        out_of_range_o
);

  eds_split_t  split;
  logic [15:0] tod_time;
  logic [15:0] time_q;

  eds_split u_split (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .epoch_seconds_i(epoch_seconds_i),
    .split_o        (split)
  );

  eds_tod u_tod (
    .clk_i     (clk_i),
    .day_sec_i (split.day_sec),
    .dos_time_o(tod_time)
  );

  eds_cal u_cal (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .split_i   (split),
    .valid_o   (done_o),
    .clamped_o (out_of_range_o),
    .dos_date_o(dos_date_o)
  );

  // time path is one stage shorter than the calendar path
  always_ff @(posedge clk_i) begin
    time_q <= tod_time;
  end

  assign dos_time_o = time_q;
  assign busy_o     = 1'b0;

endmodule

/* design/eds_checker.sv */
// port-level checks for the epoch to dos date/time converter, bound to the top level
module eds_checker
  import eds_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start_i,
  input logic        busy_o,
  input logic [31:0] epoch_seconds_i,
  input logic        done_o,
  input logic [15:0] dos_time_o,
  input logic [15:0] dos_date_o,
  input logic        out_of_range_o
);

  logic accept;
  assign accept = start_i && !busy_o;

  // every beat comes out after the fixed latency
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##8 done_o)
    else $error("accepted beat not delivered after latency");

  // no result without a beat taken at the matching edge
  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, 8))
    else $error("result strobe without accepted beat");

  // clamped results are one of the two end instants
  a_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && out_of_range_o) |->
      ((dos_time_o == 16'h0000) && (dos_date_o == MinDate)) ||
      ((dos_time_o == MaxTime) && (dos_date_o == MaxDate)))
    else $error("clamped result is not an end instant");

  // every result, clamped or in range, is a well-formed calendar value
  a_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (dos_date_o[8:5] != 4'd0) && (dos_date_o[8:5] <= 4'd12) &&
               (dos_date_o[4:0] != 5'd0) && (dos_time_o[15:11] <= 5'd23) &&
               (dos_time_o[10:5] <= 6'd59) && (dos_time_o[4:0] <= 5'd29))
    else $error("date or time field out of range");

  // the block never refuses a beat
  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_o)
    else $error("start refused");

endmodule

bind epoch_seconds_to_dos_datetime eds_checker u_eds_checker (.*);
